[hdl/cc20_pkg.sv]
// Shared types, constants and round functions for the ChaCha20 keystream block.
package cc20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  // Each double round is four half quarter-round stages.
  localparam int NUM_STAGES    = 4 * DOUBLE_ROUNDS;
  localparam int NUM_KEY_REGS  = 4;
  localparam int PADDR_W       = 5;

  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][31:0]  tail_t;
  typedef logic [7:0][63:0]  pair_arr_t;

  typedef struct packed {
    state_t work;
    tail_t  tail;
  } stage_t;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Half of a column or diagonal round: the first half uses rotations 16 and 12,
  // the second half 8 and 7. The four quarter rounds touch disjoint words.
  function automatic state_t half_round(state_t x, logic diag, logic second);
    state_t      y;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [1:0]  bs;
    logic [1:0]  cs;
    logic [1:0]  ds;
    int unsigned r1;
    int unsigned r2;
    y  = x;
    r1 = second ? 8 : 16;
    r2 = second ? 7 : 12;
    for (int i = 0; i < 4; i++) begin
      bs = 2'(i) + {1'b0, diag};
      cs = 2'(i) + {diag, 1'b0};
      ds = 2'(i) + {diag, diag};
      a  = y[{2'b00, 2'(i)}];
      b  = y[{2'b01, bs}];
      c  = y[{2'b10, cs}];
      d  = y[{2'b11, ds}];
      a  = a + b;
      d  = rotl(d ^ a, r1);
      c  = c + d;
      b  = rotl(b ^ c, r2);
      y[{2'b00, 2'(i)}] = a;
      y[{2'b01, bs}]    = b;
      y[{2'b10, cs}]    = c;
      y[{2'b11, ds}]    = d;
    end
    return y;
  endfunction

endpackage

[hdl/chacha20_block_keystream_top.sv]
// Top level of the ChaCha20 keystream block generator with its key registers.
//
// Configure the 256-bit key through the APB port while the block is idle: four
// 64-bit registers at byte addresses 0, 8, 16 and 24 (key_part0..3), reset to 0.
// Each input item (block counter plus three nonce words) yields one 64-byte
// keystream block, delivered as eight 64-bit items on the result channel in
// little-endian byte order, pair_index 0 to 7, last_pair high on pair 7.
// The rounds run in a 40-stage pipeline, one stage per half of a column or
// diagonal round (four per double round), followed by the feed-forward add into
// an output buffer. The first pair is valid once the item has passed the round
// stages into the output buffer; the remaining pairs follow one per cycle
// while out_ready_i is high, and the next block is taken as the last pair
// leaves; up to 40 further blocks queue in the round stages meanwhile.
// When the receiver stalls, the buffer holds its pair and the pipeline fills
// and then drops in_ready_o; nothing is lost or repeated.
// Reset clears all valid bits, the pair counter and the key registers.
module chacha20_block_keystream_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cc20_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  block_counter_i,
  input  logic [31:0]                  nonce_word0_i,
  input  logic [31:0]                  nonce_word1_i,
  input  logic [31:0]                  nonce_word2_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  keystream_pair_o,
  output logic [2:0]                   pair_index_o,
  output logic                         last_pair_o
);
  import cc20_pkg::*;

  logic [NUM_KEY_REGS-1:0][63:0] key_q;
  logic [1:0]                    reg_idx;

  stage_t    pipe_in;
  stage_t    pipe_out;
  logic      pipe_valid;
  logic      pipe_ready;
  state_t    sum;
  pair_arr_t obuf_q;
  logic      obuf_valid_q;
  logic [2:0] cnt_q;
  logic      out_fire;

  assign reg_idx = paddr[PADDR_W-1:3];
  assign pready  = 1'b1;
  assign prdata  = key_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (psel && penable && pwrite) begin
      key_q[reg_idx] <= pwdata;
    end
  end

  // Build the initial state: constants, key, counter, nonce.
  always_comb begin
    pipe_in.work[3:0]  = SIGMA;
    pipe_in.work[11:4] = key_q;
    pipe_in.work[12]   = block_counter_i;
    pipe_in.work[13]   = nonce_word0_i;
    pipe_in.work[14]   = nonce_word1_i;
    pipe_in.work[15]   = nonce_word2_i;
    pipe_in.tail       = pipe_in.work[15:12];
  end

  cc20_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (pipe_in),
    .out_valid_o (pipe_valid),
    .out_ready_i (pipe_ready),
    .out_data_o  (pipe_out)
  );

  // Feed-forward add; user keeps key stable while items in flight; unchecked.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i]      = pipe_out.work[i] + SIGMA[i];
      sum[12 + i] = pipe_out.work[12 + i] + pipe_out.tail[i];
    end
    for (int i = 0; i < 8; i++) begin
      sum[4 + i] = pipe_out.work[4 + i] + key_q[i / 2][(i % 2) * 32 +: 32];
    end
  end

  assign out_fire   = obuf_valid_q && out_ready_i;
  assign pipe_ready = !obuf_valid_q || (out_ready_i && (cnt_q == 3'd7));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else if (pipe_valid && pipe_ready) begin
      obuf_valid_q <= 1'b1;
      cnt_q        <= '0;
    end else if (out_fire) begin
      if (cnt_q == 3'd7) begin
        obuf_valid_q <= 1'b0;
      end
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_valid && pipe_ready) begin
      obuf_q <= sum;
    end
  end

  assign out_valid_o      = obuf_valid_q;
  assign keystream_pair_o = obuf_q[cnt_q];
  assign pair_index_o     = cnt_q;
  assign last_pair_o      = (cnt_q == 3'd7);

endmodule

[hdl/cc20_pipe.sv]
// Round pipeline: one register stage per half of a column or diagonal round.
module cc20_pipe (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cc20_pkg::stage_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cc20_pkg::stage_t out_data_o
);
  import cc20_pkg::*;

  logic   [NUM_STAGES-1:0] valid_q;
  stage_t                  data_q [NUM_STAGES];
  logic   [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = out_ready_i;
  assign in_ready_o      = rdy[0];
  assign out_valid_o     = valid_q[NUM_STAGES-1];
  assign out_data_o      = data_q[NUM_STAGES-1];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam logic DIAG   = ((k / 2) % 2) == 1;
    localparam logic SECOND = (k % 2) == 1;
    logic   src_valid;
    stage_t src_data;
    stage_t data_d;

    if (k == 0) begin : g_first
      assign src_valid = in_valid_i;
      assign src_data  = in_data_i;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_data  = data_q[k-1];
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_comb begin
      data_d.work = half_round(src_data.work, DIAG, SECOND);
      data_d.tail = src_data.tail;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_valid) begin
        data_q[k] <= data_d;
      end
    end
  end

endmodule
